/* design/wav_header_parser_defines.svh */
// Assertion macros shared by the WAV header parser modules.
// No dependencies; include in the module body after the package import.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define WAVHP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wav header parser: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define WAVHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wav header parser: next-cycle check failed");

`endif

/* design/wavhp_pkg.sv */
// Constants, status codes, result type and tag table for the WAV header parser.
// No dependencies.
`timescale 1ns / 1ps

package wavhp_pkg;

  localparam int HEADER_BYTES = 44;
  localparam int POS_W        = $clog2(HEADER_BYTES + 1);

  localparam logic [POS_W-1:0] POS_RIFF_END    = POS_W'(3);
  localparam logic [POS_W-1:0] POS_RSIZE_END   = POS_W'(7);
  localparam logic [POS_W-1:0] POS_WAVE_END    = POS_W'(11);
  localparam logic [POS_W-1:0] POS_FMT_END     = POS_W'(15);
  localparam logic [POS_W-1:0] POS_FSIZE_END   = POS_W'(19);
  localparam logic [POS_W-1:0] POS_AFMT_END    = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CHAN_END    = POS_W'(23);
  localparam logic [POS_W-1:0] POS_SRATE_END   = POS_W'(27);
  localparam logic [POS_W-1:0] POS_BRATE_END   = POS_W'(31);
  localparam logic [POS_W-1:0] POS_ALIGN_END   = POS_W'(33);
  localparam logic [POS_W-1:0] POS_BITS_END    = POS_W'(35);
  localparam logic [POS_W-1:0] POS_DATA_END    = POS_W'(39);
  localparam logic [POS_W-1:0] POS_LAST        = POS_W'(HEADER_BYTES - 1);

  localparam logic [31:0] FMT_CHUNK_SIZE = 32'd16;
  localparam logic [15:0] AUDIO_FMT_PCM  = 16'd1;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NO_RIFF   = 3'd1,
    STAT_NO_WAVE   = 3'd2,
    STAT_NO_FMT    = 3'd3,
    STAT_BAD_FSIZE = 3'd4,
    STAT_NOT_PCM   = 3'd5,
    STAT_NO_DATA   = 3'd6
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] riff_size;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
  } result_t;

  typedef struct packed {
    logic       is_tag;
    logic [7:0] char;
  } tag_info_t;

  function automatic tag_info_t tag_lookup(logic [POS_W-1:0] pos);
    tag_info_t t;
    t.is_tag = 1'b1;
    case (pos)
      POS_W'(0):  t.char = 8'h52;
      POS_W'(1):  t.char = 8'h49;
      POS_W'(2):  t.char = 8'h46;
      POS_W'(3):  t.char = 8'h46;
      POS_W'(8):  t.char = 8'h57;
      POS_W'(9):  t.char = 8'h41;
      POS_W'(10): t.char = 8'h56;
      POS_W'(11): t.char = 8'h45;
      POS_W'(12): t.char = 8'h66;
      POS_W'(13): t.char = 8'h6d;
      POS_W'(14): t.char = 8'h74;
      POS_W'(15): t.char = 8'h20;
      POS_W'(36): t.char = 8'h64;
      POS_W'(37): t.char = 8'h61;
      POS_W'(38): t.char = 8'h74;
      POS_W'(39): t.char = 8'h61;
      default: begin
        t.is_tag = 1'b0;
        t.char   = 8'h00;
      end
    endcase
    return t;
  endfunction

endpackage

/* design/wavhp_in_if.sv */
// Header byte channel: valid/ready handshake with byte and restart flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface wavhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

/* design/wavhp_out_if.sv */
// Parse result channel: valid/ready handshake with status and header fields.
// Depends on wavhp_pkg.
`timescale 1ns / 1ps

interface wavhp_out_if;
  import wavhp_pkg::*;

  logic        valid;
  logic        ready;
  status_t     status;
  logic [31:0] riff_size;
  logic [15:0] channels;
  logic [31:0] sample_rate;
  logic [31:0] byte_rate;
  logic [15:0] block_align;
  logic [15:0] sample_bits;
  logic [31:0] data_size;

  modport source (output valid, output status, output riff_size, output channels,
                  output sample_rate, output byte_rate, output block_align,
                  output sample_bits, output data_size, input ready);
  modport sink   (input valid, input status, input riff_size, input channels,
                  input sample_rate, input byte_rate, input block_align,
                  input sample_bits, input data_size, output ready);
endinterface

/* design/wavhp_parser.sv */
// Byte-serial header parser state: position, tag check, assembly and held fields.
// Depends on wavhp_pkg and wav_header_parser_defines.svh.
`timescale 1ns / 1ps

module wavhp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              restart,
  output logic              emit,
  output wavhp_pkg::result_t result
);
  import wavhp_pkg::*;
  `include "wav_header_parser_defines.svh"

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic             finished_r, finished_nxt, finished_eff;
  logic             mis_r, mis_nxt, mis_eff;
  logic [31:0]      asm_r, asm_nxt, asm_eff;
  logic [31:0]      riff_r, riff_nxt;
  logic [15:0]      chan_r, chan_nxt;
  logic [31:0]      srate_r, srate_nxt;
  logic [31:0]      brate_r, brate_nxt;
  logic [15:0]      align_r, align_nxt;
  logic [15:0]      bits_r, bits_nxt;
  logic [15:0]      half;
  tag_info_t        tag;
  logic             err;
  status_t          err_code;

  always_comb begin
    pos_eff      = restart ? '0 : pos_r;
    finished_eff = restart ? 1'b0 : finished_r;
    mis_eff      = restart ? 1'b0 : mis_r;
    asm_eff      = restart ? '0 : asm_r;

    asm_nxt  = {data_byte, asm_eff[31:8]};
    half     = asm_nxt[31:16];
    tag      = tag_lookup(pos_eff);
    mis_nxt  = mis_eff;
    if (tag.is_tag) begin
      mis_nxt = ((pos_eff[1:0] == 2'b00) ? 1'b0 : mis_eff) | (data_byte != tag.char);
    end
    pos_nxt      = pos_eff + POS_W'(1);
    finished_nxt = finished_eff;
    riff_nxt     = riff_r;
    chan_nxt     = chan_r;
    srate_nxt    = srate_r;
    brate_nxt    = brate_r;
    align_nxt    = align_r;
    bits_nxt     = bits_r;
    err          = 1'b0;
    err_code     = STAT_OK;

    case (pos_eff)
      POS_RIFF_END:  begin err = mis_nxt; err_code = STAT_NO_RIFF; end
      POS_RSIZE_END: riff_nxt = asm_nxt;
      POS_WAVE_END:  begin err = mis_nxt; err_code = STAT_NO_WAVE; end
      POS_FMT_END:   begin err = mis_nxt; err_code = STAT_NO_FMT; end
      POS_FSIZE_END: begin
        err      = (asm_nxt != FMT_CHUNK_SIZE);
        err_code = STAT_BAD_FSIZE;
      end
      POS_AFMT_END:  begin err = (half != AUDIO_FMT_PCM); err_code = STAT_NOT_PCM; end
      POS_CHAN_END:  chan_nxt  = half;
      POS_SRATE_END: srate_nxt = asm_nxt;
      POS_BRATE_END: brate_nxt = asm_nxt;
      POS_ALIGN_END: align_nxt = half;
      POS_BITS_END:  bits_nxt  = half;
      POS_DATA_END:  begin err = mis_nxt; err_code = STAT_NO_DATA; end
      default: ;
    endcase

    emit = fire && !finished_eff && (err || (pos_eff == POS_LAST));
    if (emit) begin
      finished_nxt = 1'b1;
    end

    result = '0;
    if (err) begin
      result.status = err_code;
    end else begin
      result.status      = STAT_OK;
      result.riff_size   = riff_r;
      result.channels    = chan_r;
      result.sample_rate = srate_r;
      result.byte_rate   = brate_r;
      result.block_align = align_r;
      result.sample_bits = bits_r;
      result.data_size   = asm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      finished_r <= 1'b0;
      mis_r      <= 1'b0;
      asm_r      <= '0;
    end else if (fire) begin
      if (restart || !finished_r) begin
        pos_r      <= finished_eff ? pos_eff : pos_nxt;
        finished_r <= finished_nxt;
        mis_r      <= finished_eff ? mis_eff : mis_nxt;
        asm_r      <= finished_eff ? asm_eff : asm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !finished_eff) begin
      riff_r  <= riff_nxt;
      chan_r  <= chan_nxt;
      srate_r <= srate_nxt;
      brate_r <= brate_nxt;
      align_r <= align_nxt;
      bits_r  <= bits_nxt;
    end
  end

  `WAVHP_ASSERT_IMPL(a_emit_needs_beat, clk, rst_n, emit, fire && (restart || !finished_r))
  `WAVHP_ASSERT_IMPL(a_pos_in_range, clk, rst_n, 1'b1, pos_r <= POS_W'(HEADER_BYTES))
  `WAVHP_ASSERT_NEXT(a_emit_finishes, clk, rst_n, emit, finished_r)
  `WAVHP_ASSERT_IMPL(a_err_zero_fields, clk, rst_n, emit && result.status != STAT_OK,
                     result.riff_size == '0 && result.data_size == '0)

endmodule

/* design/wav_header_parser.sv */
// Top level of the WAV header parser: byte channel in, one result per header out.
// Depends on wavhp_pkg, wavhp_in_if, wavhp_out_if, wavhp_parser and the defines header.
//
//   channel   dir  beat                              handshake
//   in_chan   in   data_byte[7:0], restart           valid/ready
//   out_chan  out  status[2:0] and seven header fields valid/ready
//
// One header byte per cycle while in_chan is not stalled; a result is registered
// from the byte that decides it (byte 43, or the last byte of the first failing field).
// Two result slots (output register plus skid) keep bytes flowing while a
// result waits; in_chan stalls only when both slots are full.
// rst_n is synchronous and active low; it clears position and handshake state.
`timescale 1ns / 1ps

module wav_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  wavhp_in_if.sink    in_chan,
  wavhp_out_if.source out_chan
);
  import wavhp_pkg::*;
  `include "wav_header_parser_defines.svh"

  logic    fire;
  logic    emit;
  logic    pop;
  result_t res;
  result_t out_r;
  result_t skid_r;
  logic    out_valid_r;
  logic    skid_valid_r;

  assign in_chan.ready = !skid_valid_r;
  assign fire          = in_chan.valid && in_chan.ready;
  assign pop           = out_valid_r && out_chan.ready;

  wavhp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_chan.data_byte),
    .restart   (in_chan.restart),
    .emit      (emit),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (emit) begin
      if (!out_valid_r || pop) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_r.status;
  assign out_chan.riff_size   = out_r.riff_size;
  assign out_chan.channels    = out_r.channels;
  assign out_chan.sample_rate = out_r.sample_rate;
  assign out_chan.byte_rate   = out_r.byte_rate;
  assign out_chan.block_align = out_r.block_align;
  assign out_chan.sample_bits = out_r.sample_bits;
  assign out_chan.data_size   = out_r.data_size;

  `WAVHP_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  `WAVHP_ASSERT_NEXT(a_emit_lands, clk, rst_n, emit, out_valid_r)
  `WAVHP_ASSERT_NEXT(a_drain_empties, clk, rst_n,
                     pop && !skid_valid_r && !emit, !out_valid_r)
  `WAVHP_ASSERT_NEXT(a_full_stall_spills, clk, rst_n,
                     emit && out_valid_r && !out_chan.ready, skid_valid_r)

endmodule
